/* rtl/pes_pkg.sv */
// shared types and constants for the pes header stripper
// used by the channel interfaces, the parser and the top level
package pes_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned REM_W  = 16;

  localparam logic [BYTE_W-1:0] CODE_ZERO = 8'h00;
  localparam logic [BYTE_W-1:0] CODE_ONE  = 8'h01;

  // parser position, one-hot
  typedef enum logic [10:0] {
    HUNT0    = 11'b000_0000_0001,
    HUNT1    = 11'b000_0000_0010,
    HUNT2    = 11'b000_0000_0100,
    SID      = 11'b000_0000_1000,
    LEN_HI   = 11'b000_0001_0000,
    LEN_LO   = 11'b000_0010_0000,
    FLAG0    = 11'b000_0100_0000,
    FLAG1    = 11'b000_1000_0000,
    HDR_LEN  = 11'b001_0000_0000,
    HDR_SKIP = 11'b010_0000_0000,
    PAYLOAD  = 11'b100_0000_0000
  } phase_t;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] es_byte;
    logic              packet_end;
  } result_t;

endpackage

/* rtl/pes_if.sv */
// stream channel interfaces: pes byte input and elementary stream output
// depends on pes_pkg for the byte width
interface pes_in_if;
  logic                       valid;
  logic                       ready;
  logic [pes_pkg::BYTE_W-1:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface pes_out_if;
  logic                       valid;
  logic                       ready;
  logic [pes_pkg::BYTE_W-1:0] es_byte;
  logic                       packet_end;

  modport source (output valid, output es_byte, output packet_end, input ready);
  modport sink (input valid, input es_byte, input packet_end, output ready);
endinterface

/* rtl/pes_to_es_payload_extractor.sv */
// top level of the pes header stripper: parser plus output register
// depends on pes_pkg, pes_if.sv and pes_parse
//
//   channel  | dir | payload                 | per word
//   data_in  | in  | data_byte[7:0]          | one pes stream byte
//   es_out   | out | es_byte[7:0], packet_end| one payload byte, end of packet flag
//
// one input word per cycle; a payload result shows in the cycle after its word
// the parser state and a single output register are the only storage
// rst (synchronous) returns the parser to start code hunt and empties the output
// a stalled output blocks input only while the output register is full
module pes_to_es_payload_extractor (
  input logic      clk,
  input logic      rst,
  pes_in_if.sink   data_in,
  pes_out_if.source es_out
);

  pes_pkg::result_t res;
  logic             step;
  logic             out_free;

  assign out_free      = !es_out.valid || es_out.ready;
  assign data_in.ready = out_free;
  assign step          = data_in.valid && data_in.ready;

  pes_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .data_byte (data_in.data_byte),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      es_out.valid <= 1'b0;
    end else if (out_free) begin
      es_out.valid <= step && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && step && res.valid) begin
      es_out.es_byte    <= res.es_byte;
      es_out.packet_end <= res.packet_end;
    end
  end

endmodule

/* rtl/pes_parse.sv */
// pes header parser: start code hunt, length and header tracking, payload pick
// depends on pes_pkg; state advances on each accepted word
module pes_parse (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       step,
  input  logic [pes_pkg::BYTE_W-1:0] data_byte,
  output pes_pkg::result_t           res
);

  pes_pkg::phase_t            phase;
  pes_pkg::phase_t            phase_next;
  logic [pes_pkg::REM_W-1:0]  remaining;
  logic [pes_pkg::REM_W-1:0]  remaining_next;
  logic [pes_pkg::REM_W-1:0]  remaining_dec;
  logic [pes_pkg::BYTE_W-1:0] header_left;
  logic [pes_pkg::BYTE_W-1:0] header_left_next;
  logic                       take_payload;

  function automatic pes_pkg::phase_t hunt_next(input pes_pkg::phase_t p,
                                                input logic [pes_pkg::BYTE_W-1:0] v);
    pes_pkg::phase_t n;
    case (p)
      pes_pkg::HUNT1: n = (v == pes_pkg::CODE_ZERO) ? pes_pkg::HUNT2 : pes_pkg::HUNT0;
      pes_pkg::HUNT2: begin
        if (v == pes_pkg::CODE_ONE) n = pes_pkg::SID;
        else if (v == pes_pkg::CODE_ZERO) n = pes_pkg::HUNT2;
        else n = pes_pkg::HUNT0;
      end
      default: n = (v == pes_pkg::CODE_ZERO) ? pes_pkg::HUNT1 : pes_pkg::HUNT0;
    endcase
    return n;
  endfunction

  // saturating count of packet bytes
  assign remaining_dec = (remaining != '0) ? remaining - 1'b1 : remaining;

  always_comb begin
    phase_next       = phase;
    remaining_next   = remaining;
    header_left_next = header_left;
    take_payload     = 1'b0;
    res.valid        = 1'b0;
    res.es_byte      = data_byte;
    res.packet_end   = 1'b0;
    unique case (phase)
      pes_pkg::HUNT0, pes_pkg::HUNT1, pes_pkg::HUNT2: begin
        phase_next = hunt_next(phase, data_byte);
      end
      pes_pkg::SID: phase_next = pes_pkg::LEN_HI;
      pes_pkg::LEN_HI: begin
        remaining_next = {data_byte, {(pes_pkg::REM_W-pes_pkg::BYTE_W){1'b0}}};
        phase_next     = pes_pkg::LEN_LO;
      end
      pes_pkg::LEN_LO: begin
        remaining_next = remaining | {{(pes_pkg::REM_W-pes_pkg::BYTE_W){1'b0}}, data_byte};
        phase_next     = pes_pkg::FLAG0;
      end
      pes_pkg::FLAG0: begin
        remaining_next = remaining_dec;
        phase_next     = pes_pkg::FLAG1;
      end
      pes_pkg::FLAG1: begin
        remaining_next = remaining_dec;
        phase_next     = pes_pkg::HDR_LEN;
      end
      pes_pkg::HDR_LEN: begin
        header_left_next = data_byte;
        remaining_next   = remaining_dec;
        phase_next       = pes_pkg::HDR_SKIP;
      end
      pes_pkg::HDR_SKIP: begin
        if (header_left != '0) begin
          header_left_next = header_left - 1'b1;
          remaining_next   = remaining_dec;
        end else begin
          // header done, this word is already payload
          take_payload = 1'b1;
        end
      end
      pes_pkg::PAYLOAD: take_payload = 1'b1;
      default: phase_next = hunt_next(pes_pkg::HUNT0, data_byte);
    endcase

    if (take_payload) begin
      if (remaining == '0) begin
        // packet already used up, treat word as start of a new hunt
        phase_next = hunt_next(pes_pkg::HUNT0, data_byte);
      end else begin
        remaining_next = remaining - 1'b1;
        res.valid      = 1'b1;
        res.packet_end = (remaining == {{(pes_pkg::REM_W-1){1'b0}}, 1'b1});
        phase_next     = res.packet_end ? pes_pkg::HUNT0 : pes_pkg::PAYLOAD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= pes_pkg::HUNT0;
      remaining   <= '0;
      header_left <= '0;
    end else if (step) begin
      phase       <= phase_next;
      remaining   <= remaining_next;
      header_left <= header_left_next;
    end
  end

`ifndef ASSERT_OFF
  a_end_rehunts: assert property (@(posedge clk) disable iff (rst)
    step && res.valid && res.packet_end |=> phase == pes_pkg::HUNT0)
    else $error("parser did not return to hunt after last payload word");

  a_payload_has_count: assert property (@(posedge clk) disable iff (rst)
    phase == pes_pkg::PAYLOAD |-> remaining != '0)
    else $error("payload phase with no packet bytes left");

  a_result_phase: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (phase == pes_pkg::PAYLOAD || phase == pes_pkg::HDR_SKIP))
    else $error("result raised outside payload phases");

  a_header_count: assert property (@(posedge clk) disable iff (rst)
    step && phase == pes_pkg::HDR_SKIP && header_left != '0
    |=> header_left == $past(header_left) - 1'b1)
    else $error("header skip count did not step down");
`endif

endmodule

/* dv/testbench.sv */
// testbench for the pes header stripper: directed and random pes byte streams,
// a bit-accurate parser model and a word-by-word check of the es output
// depends on pes_pkg, pes_if.sv and the pes_to_es_payload_extractor rtl
`timescale 1ns / 1ps

module testbench;
  import pes_pkg::*;

  typedef logic [BYTE_W-1:0] byte_q_t[$];

  typedef struct {
    logic [BYTE_W-1:0] es_byte;
    logic              packet_end;
  } es_word_t;

  logic clk;
  logic rst;

  pes_in_if  in_ch ();
  pes_out_if out_ch ();

  pes_to_es_payload_extractor u_top (
    .clk     (clk),
    .rst     (rst),
    .data_in (in_ch),
    .es_out  (out_ch)
  );

  // parser model state
  phase_t            parse_phase;
  logic [REM_W-1:0]  pkt_left;
  logic [BYTE_W-1:0] hdr_left;

  es_word_t es_expected[$];
  int       errors;
  int       bytes_sent;
  bit       send_steady;
  bit       recv_steady;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("testbench failed");
    $finish;
  end

  function automatic int draw_gap(bit steady);
    return steady ? 0 : int'($urandom_range(0, 11));
  endfunction

  function automatic void count_down();
    if (pkt_left != '0) pkt_left--;
  endfunction

  function automatic void hunt_step(logic [BYTE_W-1:0] b);
    case (parse_phase)
      HUNT1: parse_phase = (b == CODE_ZERO) ? HUNT2 : HUNT0;
      HUNT2: begin
        // extra zeros keep the start code alive
        if (b == CODE_ONE) parse_phase = SID;
        else if (b != CODE_ZERO) parse_phase = HUNT0;
      end
      default: parse_phase = (b == CODE_ZERO) ? HUNT1 : HUNT0;
    endcase
  endfunction

  function automatic void payload_step(logic [BYTE_W-1:0] b);
    if (pkt_left == '0) begin
      // nothing left: the byte goes back to the start code hunt
      parse_phase = HUNT0;
      hunt_step(b);
    end else begin
      pkt_left--;
      es_expected.push_back('{es_byte: b, packet_end: (pkt_left == '0)});
      if (pkt_left == '0) parse_phase = HUNT0;
    end
  endfunction

  function automatic void predict_byte(logic [BYTE_W-1:0] b);
    case (parse_phase)
      HUNT0, HUNT1, HUNT2: hunt_step(b);
      SID: parse_phase = LEN_HI;
      LEN_HI: begin
        pkt_left = {b, 8'h00};
        parse_phase = LEN_LO;
      end
      LEN_LO: begin
        pkt_left[7:0] = b;
        parse_phase = FLAG0;
      end
      FLAG0: begin
        count_down();
        parse_phase = FLAG1;
      end
      FLAG1: begin
        count_down();
        parse_phase = HDR_LEN;
      end
      HDR_LEN: begin
        hdr_left = b;
        count_down();
        parse_phase = HDR_SKIP;
      end
      HDR_SKIP: begin
        if (hdr_left != '0) begin
          hdr_left--;
          count_down();
        end else begin
          parse_phase = PAYLOAD;
          payload_step(b);
        end
      end
      PAYLOAD: payload_step(b);
      default: begin
        parse_phase = HUNT0;
        hunt_step(b);
      end
    endcase
  endfunction

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int gap;
    gap = draw_gap(send_steady);
    if (gap > 0) begin
      in_ch.valid     <= 1'b0;
      in_ch.data_byte <= BYTE_W'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predict_byte(b);
    bytes_sent++;
  endtask

  task automatic send_bytes(input byte_q_t seq);
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  // start code with optional extra zeros, header fields, then body_len raw bytes
  task automatic send_pes_packet(input logic [REM_W-1:0] pkt_len,
                                 input logic [BYTE_W-1:0] hdr_len, input int body_len);
    int extra;
    extra = $urandom_range(0, 2);
    repeat (extra) send_byte(CODE_ZERO);
    send_byte(CODE_ZERO);
    send_byte(CODE_ZERO);
    send_byte(CODE_ONE);
    send_byte(BYTE_W'($urandom));
    send_byte(pkt_len[15:8]);
    send_byte(pkt_len[7:0]);
    send_byte(BYTE_W'($urandom));
    send_byte(BYTE_W'($urandom));
    send_byte(hdr_len);
    repeat (body_len) send_byte(BYTE_W'($urandom));
  endtask

  task automatic test_start_code_extra_zeros();
    byte_q_t seq;
    // one extra zero, empty optional header, two payload bytes at the extremes
    seq = '{8'h00, 8'h00, 8'h00, 8'h01, 8'he0, 8'h00, 8'h05, 8'h80, 8'h80, 8'h00,
            8'hff, 8'h00};
    send_bytes(seq);
  endtask

  task automatic test_empty_packet();
    byte_q_t seq;
    // zero length saturates; header done with nothing left falls back to hunt
    seq = '{8'h00, 8'h00, 8'h01, 8'hbd, 8'h00, 8'h00, 8'h11, 8'h22, 8'h01, 8'h33,
            8'h44};
    send_bytes(seq);
  endtask

  task automatic test_random_stream();
    int start_count;
    int kind;
    int h;
    int p;
    int full;
    int len;
    start_count = bytes_sent;
    while (bytes_sent - start_count < 900) begin
      if ($urandom_range(0, 7) == 0) send_steady = !send_steady;
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        repeat ($urandom_range(0, 2))
          send_byte($urandom_range(0, 1) ? CODE_ZERO : BYTE_W'($urandom));
        h = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6);
        p = $urandom_range(1, 24);
        full = 3 + h + p;
        case ($urandom_range(0, 7))
          0: len = $urandom_range(0, full - 1);
          1: len = full + $urandom_range(1, 6);
          default: len = full;
        endcase
        send_pes_packet(REM_W'(len), BYTE_W'(h), h + p);
      end else if (kind < 9) begin
        repeat ($urandom_range(1, 8)) begin
          case ($urandom_range(0, 2))
            0: send_byte(CODE_ZERO);
            1: send_byte(CODE_ONE);
            default: send_byte(BYTE_W'($urandom));
          endcase
        end
      end else begin
        // broken start codes
        send_byte(CODE_ZERO);
        if ($urandom_range(0, 1)) begin
          send_byte(CODE_ONE);
        end else begin
          send_byte(CODE_ZERO);
          send_byte(BYTE_W'($urandom_range(2, 255)));
        end
      end
    end
    send_steady = 1'b0;
  endtask

  task automatic test_long_packets();
    // length with the high byte set that ends exactly, then the largest length
    // and header length, which the rest of the stream never uses up
    send_pes_packet(16'h0100, 8'h00, 253);
    send_pes_packet(16'hffff, 8'hff, 400);
  endtask

  // output side: random stalls, each accepted word checked against the model
  initial begin
    int       stall;
    es_word_t want;
    out_ch.ready <= 1'b0;
    wait (rst === 1'b0);
    forever begin
      stall = draw_gap(recv_steady);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      if (es_expected.size() == 0) begin
        $error("unexpected es word: es_byte=%0h packet_end=%0b",
               out_ch.es_byte, out_ch.packet_end);
        errors++;
      end else begin
        want = es_expected.pop_front();
        if (out_ch.es_byte !== want.es_byte) begin
          $error("es_byte mismatch: expected %0h, actual %0h", want.es_byte, out_ch.es_byte);
          errors++;
        end
        if (out_ch.packet_end !== want.packet_end) begin
          $error("packet_end mismatch: expected %0b, actual %0b",
                 want.packet_end, out_ch.packet_end);
          errors++;
        end
      end
      if ($urandom_range(0, 63) == 0) recv_steady = !recv_steady;
    end
  end

  initial begin
    errors          = 0;
    bytes_sent      = 0;
    send_steady     = 1'b0;
    recv_steady     = 1'b0;
    parse_phase     = HUNT0;
    pkt_left        = '0;
    hdr_left        = '0;
    rst             <= 1'b1;
    in_ch.valid     <= 1'b0;
    in_ch.data_byte <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_start_code_extra_zeros();
    test_empty_packet();
    test_random_stream();
    test_long_packets();

    in_ch.valid <= 1'b0;
    while (es_expected.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end

endmodule
